[design/assert_macros.svh]
// Assertion macros used by the checker of the stack machine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables the check.
`define SMC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stack machine port check failed");

// Condition that must never be seen at a clock edge.
`define SMC_ASSERT_NEVER(lbl, clk, rst, expr) `SMC_ASSERT(lbl, clk, rst, !(expr))

`endif

[design/smc_pkg.sv]
// Package with types, constants and helper functions of the stack machine core.
`timescale 1ns / 1ps
package smc_pkg;

   localparam int MEM_WORDS   = 8192;
   localparam int AW          = $clog2(MEM_WORDS);
   localparam int SPW         = AW + 1;
   localparam int WORD_W      = 32;
   localparam int ADDR_IN_W   = 13;
   localparam int OP_W        = 2;
   localparam int EV_W        = 3;
   localparam int DIV_CNT_W   = $clog2(WORD_W + 1);

   typedef logic [AW-1:0]     mem_addr_type;
   typedef logic [SPW-1:0]    sp_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam sp_type   SP_EMPTY  = sp_type'(MEM_WORDS);
   localparam word_type WORD_STOP = '1;

   typedef enum logic [OP_W-1:0] {
      REQ_WRITE   = 2'd0,
      REQ_EXEC    = 2'd1,
      REQ_RESTART = 2'd2,
      REQ_NOP     = 2'd3
   } req_op_type;

   typedef enum logic [EV_W-1:0] {
      EV_NONE     = 3'd0,
      EV_NUMBER   = 3'd1,
      EV_NEWLINE  = 3'd2,
      EV_HALTED   = 3'd3,
      EV_BAD_OP   = 3'd4,
      EV_DIV_ZERO = 3'd5
   } event_type;

   // Opcode classes; the value of each opcode from stop to outln is the negated instruction word.
   typedef enum logic [4:0] {
      OPC_PUSH  = 5'd0,
      OPC_STOP  = 5'd1,
      OPC_ADD   = 5'd2,
      OPC_SUB   = 5'd3,
      OPC_MUL   = 5'd4,
      OPC_DIV   = 5'd5,
      OPC_MOD   = 5'd6,
      OPC_NEG   = 5'd7,
      OPC_LOAD  = 5'd8,
      OPC_SAVE  = 5'd9,
      OPC_DUP   = 5'd10,
      OPC_DROP  = 5'd11,
      OPC_SWAP  = 5'd12,
      OPC_OVER  = 5'd13,
      OPC_GOTO  = 5'd14,
      OPC_IFEQ  = 5'd15,
      OPC_IFNE  = 5'd16,
      OPC_IFLE  = 5'd17,
      OPC_IFLT  = 5'd18,
      OPC_IFGE  = 5'd19,
      OPC_IFGT  = 5'd20,
      OPC_IN    = 5'd21,
      OPC_OUT   = 5'd22,
      OPC_OUTLN = 5'd23,
      OPC_BAD   = 5'd31
   } opc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DECODE,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EXEC,
      ST_WR2,
      ST_TOP,
      ST_TOP_W
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_WRITE_WORD,
      STEP_RESTART,
      STEP_HALT_EV,
      STEP_FETCH,
      STEP_DECODE,
      STEP_RD1,
      STEP_RD2,
      STEP_RD3,
      STEP_DIV_GO,
      STEP_EXEC,
      STEP_WR2,
      STEP_TOP,
      STEP_RESP
   } dp_step_type;

   typedef struct packed {
      logic        accept;
      dp_step_type step;
   } dp_cmd_type;

   typedef struct packed {
      req_op_type op;
      logic       halted;
      opc_type    opc;
      logic       divisor_zero;
      logic       div_busy;
   } dp_status_type;

   // Classifies an instruction word.
   function automatic opc_type decode_opc(word_type w);
      word_type code;
      opc_type  r;
      code = '0 - w;
      if (!w[WORD_W-1]) begin
         r = OPC_PUSH;
      end else if (code >= word_type'(OPC_STOP) && code <= word_type'(OPC_OUTLN)) begin
         r = opc_type'(code[4:0]);
      end else begin
         r = OPC_BAD;
      end
      return r;
   endfunction

   // Moves the stack pointer by a wrapped delta; zero stands for the empty stack.
   function automatic sp_type sp_move(sp_type s, mem_addr_type d);
      mem_addr_type r;
      r = s[AW-1:0] + d;
      return (r == '0) ? SP_EMPTY : {1'b0, r};
   endfunction

endpackage

[design/smc_divider.sv]
// Iterative signed 32-bit divider giving quotient or remainder, one bit a cycle.
`timescale 1ns / 1ps
module smc_divider import smc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   input  logic     want_mod,
   output logic     busy,
   output word_type result
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W:0]      rem_ff, rem_in;
   word_type             quo_ff, quo_in;
   word_type             ub_ff;
   logic                 neg_q_ff, neg_r_ff, mod_ff;
   logic [WORD_W:0]      shifted, diff;

   always_comb begin
      shifted = {rem_ff[WORD_W-1:0], quo_ff[WORD_W-1]};
      diff    = shifted - {1'b0, ub_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(WORD_W);
         rem_in  = '0;
         quo_in  = dividend[WORD_W-1] ? ('0 - dividend) : dividend;
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         ub_ff    <= divisor[WORD_W-1] ? ('0 - divisor) : divisor;
         neg_q_ff <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
         neg_r_ff <= dividend[WORD_W-1];
         mod_ff   <= want_mod;
      end
   end

   assign busy = busy_ff;

   always_comb begin
      if (mod_ff) begin
         result = neg_r_ff ? ('0 - rem_ff[WORD_W-1:0]) : rem_ff[WORD_W-1:0];
      end else begin
         result = neg_q_ff ? ('0 - quo_ff) : quo_ff;
      end
   end

endmodule

[design/smc_datapath.sv]
// Datapath: shared memory, pc, stack pointer, operand registers and result registers.
`timescale 1ns / 1ps
module smc_datapath import smc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ADDR_IN_W-1:0]  req_addr,
   input  logic signed [31:0]    req_data,
   input  logic signed [31:0]    req_in_value,
   output logic                  rsp_valid,
   output logic [EV_W-1:0]       rsp_event_res,
   output logic signed [31:0]    rsp_out_value,
   output logic signed [31:0]    rsp_out_width,
   output logic                  rsp_input_taken,
   output logic                  rsp_return_valid,
   output logic signed [31:0]    rsp_return_code,
   output logic [ADDR_IN_W-1:0]  rsp_pc_now
);

   word_type     mem [MEM_WORDS];
   word_type     rdata_ff;

   req_op_type   op_ff;
   mem_addr_type addr_ff;
   word_type     data_ff, in_ff;
   mem_addr_type pc_ff, pc_in;
   sp_type       sp_ff, sp_in;
   logic         halted_ff, halted_in;
   word_type     cmd_ff, t0_ff, t1_ff, t2_ff;
   event_type    ev_ff, ev_in;
   word_type     ov_ff, ov_in, ow_ff, ow_in;
   logic         taken_ff, taken_in;

   logic         rsp_valid_ff;
   event_type    rsp_ev_ff;
   word_type     rsp_ov_ff, rsp_ow_ff, rsp_code_ff;
   logic         rsp_taken_ff, rsp_rv_ff;
   mem_addr_type rsp_pc_ff;

   mem_addr_type slot0, slot1, slot2, push_addr;
   mem_addr_type raddr, waddr;
   word_type     wdata;
   logic         we;
   opc_type      opc;
   logic         cond;
   word_type     div_result;
   logic         div_busy;
   logic         stack_valid;

   assign slot0     = sp_ff[AW-1:0];
   assign slot1     = slot0 + mem_addr_type'(1);
   assign slot2     = slot0 + mem_addr_type'(2);
   assign push_addr = slot0 - mem_addr_type'(1);
   assign opc       = decode_opc(cmd_ff);

   smc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.step == STEP_DIV_GO),
      .dividend (t1_ff),
      .divisor  (t0_ff),
      .want_mod (opc == OPC_MOD),
      .busy     (div_busy),
      .result   (div_result)
   );

   assign status.op           = op_ff;
   assign status.halted       = halted_ff;
   assign status.opc          = opc;
   assign status.divisor_zero = (t0_ff == '0);
   assign status.div_busy     = div_busy;

   always_comb begin
      case (cmd.step)
         STEP_FETCH:  raddr = pc_ff;
         STEP_DECODE: raddr = slot0;
         STEP_RD1:    raddr = slot1;
         STEP_RD2:    raddr = slot2;
         STEP_RD3:    raddr = mem_addr_type'(t0_ff);
         default:     raddr = slot0;
      endcase
   end

   always_comb begin
      case (opc)
         OPC_IFEQ: cond = (t2_ff == t1_ff);
         OPC_IFNE: cond = (t2_ff != t1_ff);
         OPC_IFLE: cond = ($signed(t2_ff) <= $signed(t1_ff));
         OPC_IFLT: cond = ($signed(t2_ff) < $signed(t1_ff));
         OPC_IFGE: cond = ($signed(t2_ff) >= $signed(t1_ff));
         default:  cond = ($signed(t2_ff) > $signed(t1_ff));
      endcase
   end

   always_comb begin
      we        = 1'b0;
      waddr     = slot0;
      wdata     = t0_ff;
      pc_in     = pc_ff;
      sp_in     = sp_ff;
      halted_in = halted_ff;
      ev_in     = ev_ff;
      ov_in     = ov_ff;
      ow_in     = ow_ff;
      taken_in  = taken_ff;
      unique case (cmd.step)
         STEP_WRITE_WORD: begin
            we    = 1'b1;
            waddr = addr_ff;
            wdata = data_ff;
         end
         STEP_RESTART: begin
            pc_in     = '0;
            sp_in     = SP_EMPTY;
            halted_in = 1'b0;
         end
         STEP_HALT_EV: ev_in = EV_HALTED;
         STEP_DECODE:  pc_in = pc_ff + mem_addr_type'(1);
         STEP_WR2: begin
            we    = 1'b1;
            waddr = slot1;
            wdata = t0_ff;
         end
         STEP_EXEC: begin
            case (opc)
               OPC_PUSH: begin
                  we    = 1'b1;
                  waddr = push_addr;
                  wdata = cmd_ff;
                  sp_in = sp_move(sp_ff, '1);
               end
               OPC_STOP: begin
                  halted_in = 1'b1;
                  ev_in     = EV_HALTED;
               end
               OPC_ADD, OPC_SUB, OPC_MUL: begin
                  we    = 1'b1;
                  waddr = slot1;
                  if (opc == OPC_ADD) begin
                     wdata = t1_ff + t0_ff;
                  end else if (opc == OPC_SUB) begin
                     wdata = t1_ff - t0_ff;
                  end else begin
                     wdata = word_type'(t1_ff * t0_ff);
                  end
                  sp_in = sp_move(sp_ff, mem_addr_type'(1));
               end
               OPC_DIV, OPC_MOD: begin
                  if (t0_ff == '0) begin
                     halted_in = 1'b1;
                     ev_in     = EV_DIV_ZERO;
                  end else begin
                     we    = 1'b1;
                     waddr = slot1;
                     wdata = div_result;
                     sp_in = sp_move(sp_ff, mem_addr_type'(1));
                  end
               end
               OPC_NEG: begin
                  we    = 1'b1;
                  wdata = '0 - t0_ff;
               end
               OPC_LOAD: begin
                  we    = 1'b1;
                  wdata = rdata_ff;
               end
               OPC_SAVE: begin
                  we    = 1'b1;
                  waddr = mem_addr_type'(t1_ff);
                  sp_in = sp_move(sp_ff, mem_addr_type'(2));
               end
               OPC_DUP: begin
                  we    = 1'b1;
                  waddr = push_addr;
                  sp_in = sp_move(sp_ff, '1);
               end
               OPC_DROP: sp_in = sp_move(sp_ff, mem_addr_type'(1));
               OPC_SWAP: begin
                  we    = 1'b1;
                  wdata = t1_ff;
               end
               OPC_OVER: begin
                  we    = 1'b1;
                  waddr = push_addr;
                  wdata = t1_ff;
                  sp_in = sp_move(sp_ff, '1);
               end
               OPC_GOTO: begin
                  pc_in = mem_addr_type'(t0_ff);
                  sp_in = sp_move(sp_ff, mem_addr_type'(1));
               end
               OPC_IFEQ, OPC_IFNE, OPC_IFLE, OPC_IFLT, OPC_IFGE, OPC_IFGT: begin
                  if (cond) begin
                     pc_in = mem_addr_type'(t0_ff);
                  end
                  sp_in = sp_move(sp_ff, mem_addr_type'(3));
               end
               OPC_IN: begin
                  we       = 1'b1;
                  waddr    = push_addr;
                  wdata    = in_ff;
                  sp_in    = sp_move(sp_ff, '1);
                  taken_in = 1'b1;
               end
               OPC_OUT: begin
                  ow_in = t0_ff;
                  ov_in = t1_ff;
                  ev_in = EV_NUMBER;
                  sp_in = sp_move(sp_ff, mem_addr_type'(2));
               end
               OPC_OUTLN: ev_in = EV_NEWLINE;
               default: begin
                  we    = 1'b1;
                  waddr = pc_ff;
                  wdata = WORD_STOP;
                  ev_in = EV_BAD_OP;
               end
            endcase
         end
         default: ;
      endcase
      if (cmd.accept) begin
         ev_in    = EV_NONE;
         ov_in    = '0;
         ow_in    = '0;
         taken_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign stack_valid = (sp_ff != SP_EMPTY);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         sp_ff        <= SP_EMPTY;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         sp_ff        <= sp_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= (cmd.step == STEP_RESP);
      end
      ev_ff    <= ev_in;
      ov_ff    <= ov_in;
      ow_ff    <= ow_in;
      taken_ff <= taken_in;
      if (cmd.accept) begin
         op_ff   <= req_op_type'(req_op);
         addr_ff <= mem_addr_type'(req_addr);
         data_ff <= word_type'(req_data);
         in_ff   <= word_type'(req_in_value);
      end
      if (cmd.step == STEP_DECODE) begin
         cmd_ff <= rdata_ff;
      end
      if (cmd.step == STEP_RD1) begin
         t0_ff <= rdata_ff;
      end
      if (cmd.step == STEP_RD2) begin
         t1_ff <= rdata_ff;
      end
      if (cmd.step == STEP_RD3) begin
         t2_ff <= rdata_ff;
      end
      if (cmd.step == STEP_RESP) begin
         rsp_ev_ff    <= ev_ff;
         rsp_ov_ff    <= ov_ff;
         rsp_ow_ff    <= ow_ff;
         rsp_taken_ff <= taken_ff;
         rsp_rv_ff    <= stack_valid;
         rsp_code_ff  <= stack_valid ? rdata_ff : '0;
         rsp_pc_ff    <= pc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ev_ff;
   assign rsp_out_value    = rsp_ov_ff;
   assign rsp_out_width    = rsp_ow_ff;
   assign rsp_input_taken  = rsp_taken_ff;
   assign rsp_return_valid = rsp_rv_ff;
   assign rsp_return_code  = rsp_code_ff;
   assign rsp_pc_now       = ADDR_IN_W'(rsp_pc_ff);

endmodule

[design/smc_controller.sv]
// Controller state machine sequencing memory accesses and the divider per beat.
`timescale 1ns / 1ps
module smc_controller import smc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.step   = STEP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.op)
               REQ_WRITE: begin
                  cmd.step = STEP_WRITE_WORD;
                  state_in = ST_TOP;
               end
               REQ_RESTART: begin
                  cmd.step = STEP_RESTART;
                  state_in = ST_TOP;
               end
               REQ_EXEC: begin
                  if (status.halted) begin
                     cmd.step = STEP_HALT_EV;
                     state_in = ST_TOP;
                  end else begin
                     cmd.step = STEP_FETCH;
                     state_in = ST_DECODE;
                  end
               end
               REQ_NOP: state_in = ST_TOP;
            endcase
         end
         ST_DECODE: begin
            cmd.step = STEP_DECODE;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.step = STEP_RD1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            cmd.step = STEP_RD2;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            cmd.step = STEP_RD3;
            if ((status.opc == OPC_DIV || status.opc == OPC_MOD) && !status.divisor_zero) begin
               state_in = ST_DIV_GO;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_DIV_GO: begin
            cmd.step = STEP_DIV_GO;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.step = STEP_EXEC;
            state_in = (status.opc == OPC_SWAP) ? ST_WR2 : ST_TOP;
         end
         ST_WR2: begin
            cmd.step = STEP_WR2;
            state_in = ST_TOP;
         end
         ST_TOP: begin
            cmd.step = STEP_TOP;
            state_in = ST_TOP_W;
         end
         ST_TOP_W: begin
            cmd.step = STEP_RESP;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[design/stack_machine_core_unit.sv]
// Top level of the stack machine core: controller and datapath.
// A write, restart, no-op or halted exec beat goes from dispatch straight to the top-of-stack
// read and the response; an executed instruction adds fetch, decode, stack and load reads and
// execute (a second write for swap); div and mod wait on the divider, one quotient bit a cycle.
// Throughput: one beat at a time; the next beat is taken only once the block is idle again.
// Reset (synchronous, active high) clears pc, empties the stack, clears halted; memory is kept.
`timescale 1ns / 1ps
module stack_machine_core_unit import smc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [ADDR_IN_W-1:0]  req_addr,
   input  logic signed [31:0]    req_data,
   input  logic signed [31:0]    req_in_value,
   output logic                  rsp_valid,
   output logic [EV_W-1:0]       rsp_event_res,
   output logic signed [31:0]    rsp_out_value,
   output logic signed [31:0]    rsp_out_width,
   output logic                  rsp_input_taken,
   output logic                  rsp_return_valid,
   output logic signed [31:0]    rsp_return_code,
   output logic [ADDR_IN_W-1:0]  rsp_pc_now
);

   // The controller walks each beat through its memory accesses and tells the datapath
   // what to do in every cycle; the datapath reports the request kind, the decoded opcode,
   // the halted flag, the divisor-zero flag and divider progress back.
   dp_cmd_type    cmd;
   dp_status_type status;

   smc_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // The datapath holds the shared program/data/stack memory and registers the result,
   // which is shown for exactly one cycle; the next beat may be accepted in that cycle.
   smc_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_addr         (req_addr),
      .req_data         (req_data),
      .req_in_value     (req_in_value),
      .rsp_valid        (rsp_valid),
      .rsp_event_res    (rsp_event_res),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_width    (rsp_out_width),
      .rsp_input_taken  (rsp_input_taken),
      .rsp_return_valid (rsp_return_valid),
      .rsp_return_code  (rsp_return_code),
      .rsp_pc_now       (rsp_pc_now)
   );

endmodule

[design/smc_checker.sv]
// Port-level checker for the stack machine core and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smc_checker import smc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [EV_W-1:0]      rsp_event_res,
   input logic                 rsp_return_valid,
   input logic signed [31:0]   rsp_return_code
);

   // An accepted beat keeps the block busy in the next cycle.
   `SMC_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   // A result only ends a busy stretch.
   `SMC_ASSERT(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy))
   // The result strobe is never asserted back to back.
   `SMC_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   // An empty stack reports a zero return code.
   `SMC_ASSERT_NEVER(a_empty_code, clock, reset,
      rsp_valid && !rsp_return_valid && rsp_return_code != 0)
   // Event codes stay within the defined set.
   `SMC_ASSERT_NEVER(a_event_range, clock, reset, rsp_valid && rsp_event_res > EV_DIV_ZERO)

endmodule

bind stack_machine_core_unit smc_checker u_smc_checker (.*);
